// File: design/pncm_pkg.sv
package pncm_pkg;

  localparam int DEFAULT_ENTRIES = 256;

  localparam int COMP_W  = 8;
  localparam int INDEX_W = 8;
  localparam int CODE_W  = 32;
  localparam int COUNT_W = 9;
  localparam int OP_W    = 2;
  localparam int MODE_W  = 2;
  // three squares of 8-bit differences sum to at most 3 * 255^2
  localparam int DIST_W  = 18;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_MATCH = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  localparam logic [MODE_W-1:0] MODE_INDEXED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RGB565  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ARGB    = 2'd2;

  localparam logic [CODE_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;

  typedef struct packed {
    logic latch_in;
    logic clr_step;
    logic do_write;
    logic rd_item;
    logic scan_start;
    logic scan_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            indexed;
    logic            clr_last;
    logic            scan_last;
    logic            pipe_busy;
    logic            out_free;
  } status_t;

  function automatic logic [CODE_W-1:0] pack_565(input logic [COMP_W-1:0] r,
                                                 input logic [COMP_W-1:0] g,
                                                 input logic [COMP_W-1:0] b);
    pack_565 = {16'd0, r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// File: design/pncm_req_if.sv
interface pncm_req_if;
  logic                          valid;
  logic                          ready;
  logic [pncm_pkg::OP_W-1:0]     opcode;
  logic [pncm_pkg::INDEX_W-1:0]  entry_index;
  logic [pncm_pkg::COMP_W-1:0]   red_in;
  logic [pncm_pkg::COMP_W-1:0]   green_in;
  logic [pncm_pkg::COMP_W-1:0]   blue_in;

  modport source (output valid, opcode, entry_index, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, opcode, entry_index, red_in, green_in, blue_in,
                output ready);
endinterface

// File: design/pncm_rsp_if.sv
interface pncm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pncm_pkg::CODE_W-1:0]   color_code;
  logic [pncm_pkg::COMP_W-1:0]   red_out;
  logic [pncm_pkg::COMP_W-1:0]   green_out;
  logic [pncm_pkg::COMP_W-1:0]   blue_out;
  logic [pncm_pkg::COUNT_W-1:0]  entries_in_use;

  modport source (output valid, color_code, red_out, green_out, blue_out,
                  entries_in_use, input ready);
  modport sink (input valid, color_code, red_out, green_out, blue_out,
                entries_in_use, output ready);
endinterface

// File: design/pncm_ctrl.sv
module pncm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  pncm_pkg::status_t  status,
  output pncm_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_EXEC  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready    = 1'b1;
        cmd.latch_in = req_valid;
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_EMIT;
        case (status.op)
          pncm_pkg::OP_WRITE: cmd.do_write = 1'b1;
          pncm_pkg::OP_READ:  cmd.rd_item  = 1'b1;
          pncm_pkg::OP_MATCH: begin
            if (status.indexed) begin
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
          end
          default: state_next = ST_EMIT;
        endcase
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last distance to reach the compare stage
        if (!status.pipe_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

`ifndef SYNTHESIS
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !status.out_free) |=> state == ST_EMIT)
    else $error("result dropped while output stalled");

  a_scan_to_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && status.scan_last) |=> (state == ST_DRAIN && status.pipe_busy))
    else $error("scan pipeline empty after last read");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state not one-hot");
`endif

endmodule

// File: design/pncm_datapath.sv
module pncm_datapath #(
  parameter int PALETTE_ENTRIES = pncm_pkg::DEFAULT_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [pncm_pkg::MODE_W-1:0]    cfg_wr_data,
  input  logic [pncm_pkg::OP_W-1:0]      opcode,
  input  logic [pncm_pkg::INDEX_W-1:0]   entry_index,
  input  logic [pncm_pkg::COMP_W-1:0]    red_in,
  input  logic [pncm_pkg::COMP_W-1:0]    green_in,
  input  logic [pncm_pkg::COMP_W-1:0]    blue_in,
  input  pncm_pkg::cmd_t                 cmd,
  output pncm_pkg::status_t              status,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [pncm_pkg::CODE_W-1:0]    color_code,
  output logic [pncm_pkg::COMP_W-1:0]    red_out,
  output logic [pncm_pkg::COMP_W-1:0]    green_out,
  output logic [pncm_pkg::COMP_W-1:0]    blue_out,
  output logic [pncm_pkg::COUNT_W-1:0]   entries_in_use
);

  localparam int IDX_W   = $clog2(PALETTE_ENTRIES);
  localparam int ENTRY_W = 3 * pncm_pkg::COMP_W;
  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(PALETTE_ENTRIES - 1);

  logic [pncm_pkg::MODE_W-1:0]  color_mode;
  logic [pncm_pkg::OP_W-1:0]    op;
  logic [pncm_pkg::INDEX_W-1:0] idx;
  logic [pncm_pkg::COMP_W-1:0]  red;
  logic [pncm_pkg::COMP_W-1:0]  green;
  logic [pncm_pkg::COMP_W-1:0]  blue;
  logic [pncm_pkg::COUNT_W-1:0] used_count;

  logic [ENTRY_W-1:0] palette [PALETTE_ENTRIES];
  logic [ENTRY_W-1:0] rdata;
  logic [IDX_W-1:0]   clr_addr;
  logic [IDX_W-1:0]   scan_addr;

  logic                         rd_v;
  logic [IDX_W-1:0]             rd_idx;
  logic                         dist_v;
  logic [IDX_W-1:0]             dist_idx;
  logic [pncm_pkg::DIST_W-1:0]  dist_q;
  logic [pncm_pkg::DIST_W-1:0]  best_dist;
  logic [IDX_W-1:0]             best_idx;

  logic                         in_range;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic [ENTRY_W-1:0]           wr_data;
  logic                         rd_en;
  logic [IDX_W-1:0]             rd_addr;
  logic [pncm_pkg::DIST_W-1:0]  dist_calc;

  logic [pncm_pkg::CODE_W-1:0]  color_code_next;
  logic [pncm_pkg::COMP_W-1:0]  red_out_next;
  logic [pncm_pkg::COMP_W-1:0]  green_out_next;
  logic [pncm_pkg::COMP_W-1:0]  blue_out_next;

  function automatic logic [2*pncm_pkg::COMP_W-1:0] sq_diff(
      input logic [pncm_pkg::COMP_W-1:0] a, input logic [pncm_pkg::COMP_W-1:0] b);
    logic [pncm_pkg::COMP_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    sq_diff = d * d;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= pncm_pkg::MODE_INDEXED;
    end else if (cfg_wr_en) begin
      color_mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op    <= opcode;
      idx   <= entry_index;
      red   <= red_in;
      green <= green_in;
      blue  <= blue_in;
    end
  end

  assign in_range = int'(idx) < PALETTE_ENTRIES;

  // one write port shared by the clearing pass and entry writes
  assign wr_en   = cmd.clr_step || (cmd.do_write && in_range);
  assign wr_addr = cmd.clr_step ? clr_addr : IDX_W'(idx);
  assign wr_data = cmd.clr_step ? '0 : {red, green, blue};

  // one read port shared by the scan and entry reads
  assign rd_en   = cmd.rd_item || cmd.scan_step;
  assign rd_addr = cmd.scan_step ? scan_addr : IDX_W'(idx);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= palette[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr <= '0;
    end else if (cmd.scan_step) begin
      scan_addr <= scan_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
    end else if (cmd.do_write && in_range && used_count <= {1'b0, idx}) begin
      used_count <= {1'b0, idx} + 1'b1;
    end
  end

  assign dist_calc = pncm_pkg::DIST_W'(sq_diff(rdata[23:16], red))
                   + pncm_pkg::DIST_W'(sq_diff(rdata[15:8], green))
                   + pncm_pkg::DIST_W'(sq_diff(rdata[7:0], blue));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      dist_v <= 1'b0;
    end else begin
      rd_v   <= cmd.scan_step;
      dist_v <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx   <= scan_addr;
    dist_idx <= rd_idx;
    dist_q   <= dist_calc;
  end

  // entry zero seeds the search; strict less keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (dist_v && (dist_idx == '0 || dist_q < best_dist)) begin
      best_dist <= dist_q;
      best_idx  <= dist_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    color_code_next = '0;
    red_out_next    = '0;
    green_out_next  = '0;
    blue_out_next   = '0;
    case (op)
      pncm_pkg::OP_MATCH: begin
        case (color_mode)
          pncm_pkg::MODE_INDEXED: color_code_next = pncm_pkg::CODE_W'(best_idx);
          pncm_pkg::MODE_RGB565:  color_code_next = pncm_pkg::pack_565(red, green, blue);
          pncm_pkg::MODE_ARGB:
            color_code_next = pncm_pkg::ALPHA_OPAQUE | {8'd0, red, green, blue};
          default: color_code_next = '0;
        endcase
      end
      pncm_pkg::OP_READ: begin
        if (in_range) begin
          red_out_next   = rdata[23:16];
          green_out_next = rdata[15:8];
          blue_out_next  = rdata[7:0];
        end
      end
      default: color_code_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      color_code     <= color_code_next;
      red_out        <= red_out_next;
      green_out      <= green_out_next;
      blue_out       <= blue_out_next;
      entries_in_use <= used_count;
    end
  end

  assign status.op        = op;
  assign status.indexed   = (color_mode == pncm_pkg::MODE_INDEXED);
  assign status.clr_last  = (clr_addr == LAST_ADDR);
  assign status.scan_last = (scan_addr == LAST_ADDR);
  assign status.pipe_busy = rd_v || dist_v;
  assign status.out_free  = !rsp_valid || rsp_ready;

`ifndef SYNTHESIS
  a_count_covers_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.do_write && in_range) |=> used_count > {1'b0, $past(idx)})
    else $error("entry count below written index");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp_valid || rsp_ready))
    else $error("result overwrites a pending word");

  a_dist_follows_read: assert property (@(posedge clk) disable iff (rst)
    dist_v |-> $past(rd_v))
    else $error("distance stage without a read");
`endif

endmodule

// File: design/palette_nearest_color_matcher.sv
// Palette nearest color matcher.
// req carries one word per operation: opcode (write entry, match color,
// read entry), entry_index and an RGB color. rsp returns one word per
// request: color_code, the read components and entries_in_use.
// cfg_wr_en/cfg_wr_data set the color mode (indexed search, RGB565 pack,
// ARGB8888 pack); write it only while no request is in flight.
// Writes, reads, packed matches and unused opcodes pass from the taken
// request through the execute state to the output register; an indexed
// match first scans the palette through the single read port of the
// palette memory, one entry per cycle, then drains a two-stage distance pipe.
// One request is in flight at a time; the next can be taken in the cycle
// after the previous result is loaded into the output register.
// Reset clears the mode and the entry count, then a clearing pass zeroes the
// whole palette with req.ready low.
// A stalled rsp holds its word; the block takes the next request meanwhile
// and waits with its result until the output register frees.
module palette_nearest_color_matcher #(
  parameter int PALETTE_ENTRIES = pncm_pkg::DEFAULT_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [pncm_pkg::MODE_W-1:0]  cfg_wr_data,
  pncm_req_if.sink                     req,
  pncm_rsp_if.source                   rsp
);

  pncm_pkg::cmd_t    cmd;
  pncm_pkg::status_t status;

  pncm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pncm_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .opcode         (req.opcode),
    .entry_index    (req.entry_index),
    .red_in         (req.red_in),
    .green_in       (req.green_in),
    .blue_in        (req.blue_in),
    .cmd            (cmd),
    .status         (status),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .color_code     (rsp.color_code),
    .red_out        (rsp.red_out),
    .green_out      (rsp.green_out),
    .blue_out       (rsp.blue_out),
    .entries_in_use (rsp.entries_in_use)
  );

endmodule

// File: tb/palette_nearest_color_matcher_tb.sv
module palette_nearest_color_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pncm_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int ENTRIES       = DEFAULT_ENTRIES;
  localparam int SCAN_LATENCY  = ENTRIES + 5;
  localparam int SEGMENTS      = 18;
  localparam int SEGMENT_WORDS = 30;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [COMP_W-1:0]  red;
    logic [COMP_W-1:0]  green;
    logic [COMP_W-1:0]  blue;
    logic [COUNT_W-1:0] in_use;
  } palette_reply_t;

  class palette_shadow;
    logic [3*COMP_W-1:0] colors [ENTRIES];
    logic [COUNT_W-1:0]  used;
    logic [MODE_W-1:0]   mode;
    palette_reply_t      replies_due [$];
    int                  mismatches;

    function new();
      foreach (colors[i]) colors[i] = '0;
      used = '0;
      mode = MODE_INDEXED;
      mismatches = 0;
    endfunction

    // least squared RGB distance over every entry; ties keep the lowest index
    function logic [CODE_W-1:0] nearest(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                                        logic [COMP_W-1:0] b);
      int best_dist;
      int sum_sq;
      int dr;
      int dg;
      int db;
      logic [CODE_W-1:0] best;
      best = '0;
      best_dist = 1 << 20;
      for (int i = 0; i < ENTRIES; i++) begin
        dr = int'(colors[i][23:16]) - int'(r);
        dg = int'(colors[i][15:8]) - int'(g);
        db = int'(colors[i][7:0]) - int'(b);
        sum_sq = dr * dr + dg * dg + db * db;
        if (sum_sq < best_dist) begin
          best_dist = sum_sq;
          best = i;
        end
      end
      return best;
    endfunction

    function void take_request(logic [OP_W-1:0] op, logic [INDEX_W-1:0] idx,
                               logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                               logic [COMP_W-1:0] b);
      palette_reply_t rep;
      rep = '0;
      case (op)
        OP_WRITE: begin
          colors[idx] = {r, g, b};
          if (used <= idx) used = {1'b0, idx} + 1'b1;
        end
        OP_MATCH: begin
          case (mode)
            MODE_INDEXED: rep.code = nearest(r, g, b);
            MODE_RGB565:  rep.code = {16'd0, r[7:3], g[7:2], b[7:3]};
            MODE_ARGB:    rep.code = ALPHA_OPAQUE | {8'd0, r, g, b};
            default:      rep.code = '0;
          endcase
        end
        OP_READ: {rep.red, rep.green, rep.blue} = colors[idx];
        default: ;
      endcase
      rep.in_use = used;
      replies_due.push_back(rep);
    endfunction

    function void check_reply(palette_reply_t got);
      palette_reply_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: reply with none pending: %p", $realtime, got);
        return;
      end
      want = replies_due.pop_front();
      if (got.code !== want.code || got.red !== want.red || got.green !== want.green ||
          got.blue !== want.blue || got.in_use !== want.in_use) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: reply mismatch (exp/act) code %h/%h rgb %h%h%h/%h%h%h used %0d/%0d",
                   $realtime, want.code, got.code, want.red, want.green, want.blue,
                   got.red, got.green, got.blue, want.in_use, got.in_use);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [MODE_W-1:0]   cfg_wr_data;
  int                  send_idle_pct;
  int                  take_idle_pct;
  palette_shadow       shadow;

  pncm_req_if req_bus ();
  pncm_rsp_if rsp_bus ();

  palette_nearest_color_matcher dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_bus),
    .rsp         (rsp_bus)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin : reply_monitor
    palette_reply_t got;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got = '{code: rsp_bus.color_code, red: rsp_bus.red_out, green: rsp_bus.green_out,
              blue: rsp_bus.blue_out, in_use: rsp_bus.entries_in_use};
      shadow.check_reply(got);
    end
    rsp_bus.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                           input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
                           input logic [COMP_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.opcode      <= op;
    req_bus.entry_index <= idx;
    req_bus.red_in      <= r;
    req_bus.green_in    <= g;
    req_bus.blue_in     <= b;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    shadow.take_request(op, idx, r, g, b);
  endtask

  // drain every pending word, then write the mode
  task automatic load_mode(input logic [MODE_W-1:0] m);
    req_bus.valid <= 1'b0;
    while (shadow.replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow.mode = m;
  endtask

  function automatic logic [COMP_W-1:0] nudge(logic [COMP_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return COMP_W'(v);
  endfunction

  task automatic send_random_word();
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] idx;
    logic [COMP_W-1:0]  r;
    logic [COMP_W-1:0]  g;
    logic [COMP_W-1:0]  b;
    int                 pick;
    pick = $urandom_range(99);
    op = (pick < 35) ? OP_WRITE : (pick < 70) ? OP_MATCH : (pick < 95) ? OP_READ : OP_UNUSED;
    pick = $urandom_range(9);
    idx = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(255));
    pick = $urandom_range(9);
    {r, g, b} = shadow.colors[$urandom_range(ENTRIES - 1)];
    case (pick)
      0: {r, g, b} = '0;
      1: {r, g, b} = '1;
      // aim near a stored color so the search has close rivals
      2, 3, 4: begin
        r = nudge(r);
        g = nudge(g);
        b = nudge(b);
      end
      // keep the stored color as is: duplicates make ties
      5: ;
      default: {r, g, b} = 24'($urandom);
    endcase
    send_word(op, idx, r, g, b);
  endtask

  initial begin
    logic [MODE_W-1:0] seg_modes [6];
    seg_modes = '{MODE_INDEXED, MODE_RGB565, MODE_INDEXED, MODE_ARGB, MODE_INDEXED,
                  MODE_UNUSED};
    shadow = new();
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = MODE_INDEXED;
    req_bus.valid = 1'b0;
    req_bus.opcode = OP_WRITE;
    req_bus.entry_index = '0;
    req_bus.red_in = '0;
    req_bus.green_in = '0;
    req_bus.blue_in = '0;
    rsp_bus.ready = 1'b0;
    send_idle_pct = 32;
    take_idle_pct = 64;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty palette: every entry ties, lowest index wins
    send_word(OP_MATCH, 0, 10, 20, 30);
    send_word(OP_READ, 255, 0, 0, 0);
    send_word(OP_WRITE, 5, 1, 2, 3);
    send_word(OP_WRITE, 3, 255, 255, 255);
    send_word(OP_WRITE, 7, 0, 0, 2);
    send_word(OP_READ, 3, 0, 0, 0);
    send_word(OP_MATCH, 0, 255, 255, 255);
    send_word(OP_MATCH, 0, 0, 0, 1);
    send_word(OP_UNUSED, 200, 255, 255, 255);
    send_word(OP_WRITE, 255, 255, 0, 255);
    send_word(OP_MATCH, 0, 250, 10, 250);
    send_word(OP_READ, 255, 0, 0, 0);
    load_mode(MODE_RGB565);
    send_word(OP_MATCH, 0, 255, 255, 255);
    send_word(OP_MATCH, 0, 0, 0, 0);
    send_word(OP_MATCH, 0, 8'hAA, 8'h55, 8'hF8);
    send_word(OP_READ, 5, 0, 0, 0);
    load_mode(MODE_ARGB);
    send_word(OP_MATCH, 0, 255, 255, 255);
    send_word(OP_MATCH, 0, 0, 0, 0);
    send_word(OP_MATCH, 0, 8'h12, 8'h34, 8'h56);
    load_mode(MODE_UNUSED);
    send_word(OP_MATCH, 0, 255, 255, 255);
    send_word(OP_UNUSED, 0, 0, 0, 0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 6)
        0: begin
          send_idle_pct = 32;
          take_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          take_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      load_mode(seg_modes[seg % 6]);
      repeat (SEGMENT_WORDS) send_random_word();
    end

    req_bus.valid <= 1'b0;
    while (shadow.replies_due.size() != 0) @(posedge clk);
    repeat (SCAN_LATENCY + 10) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.replies_due.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
design/pncm_pkg.sv
design/pncm_req_if.sv
design/pncm_rsp_if.sv
design/pncm_ctrl.sv
design/pncm_datapath.sv
design/palette_nearest_color_matcher.sv
tb/palette_nearest_color_matcher_tb.sv
